[src/hrs_pkg.sv]
// Shared types and constants for the histogram row smoothing kernel.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package hrs_pkg;

  localparam int KW_BITS      = 4;
  localparam int SMEAR_BITS   = 26;
  localparam int COL_OUT_BITS = 7;

  localparam int DEF_MAX_KERNEL_WIDTH = 15;
  localparam int DEF_MAX_COLUMNS      = 128;
  localparam int DEF_ENERGY_BITS      = 24;

  typedef logic [KW_BITS-1:0] step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  accept;
    logic  issue;
    logic  load_out;
    logic  next_col;
    step_t step;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic emit;
    logic step_last;
    logic job_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[src/hrs_ram.sv]
// Generic RAM with one write port and two registered read ports.
// Stand-alone; holds the window of unsmoothed bins.
`default_nettype none

module hrs_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 32,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr_a,
  output logic      [WIDTH-1:0]     rdata_a,
  input  wire logic [ADDR_BITS-1:0] raddr_b,
  output logic      [WIDTH-1:0]     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[src/hrs_ctrl.sv]
// Controller of the smoothing kernel: sequences accept, window reads per
// offset, and loading of the output register. Depends on hrs_pkg.
`default_nettype none

module hrs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output hrs_pkg::cmd_t      cmd,
  input  wire hrs_pkg::sts_t sts
);
  import hrs_pkg::*;

  state_t st_r, st_nxt;
  step_t  step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
  end

  // Next state.
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    unique case (st_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_valid && sts.emit) begin
          st_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (sts.step_last) begin
          st_nxt = ST_LAST;
        end else begin
          step_nxt = step_r + step_t'(1);
        end
      end
      ST_LAST: begin
        st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          step_nxt = '0;
          st_nxt   = sts.job_end ? ST_IDLE : ST_READ;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.issue    = 1'b0;
    cmd.load_out = 1'b0;
    cmd.next_col = 1'b0;
    cmd.step     = step_r;
    unique case (st_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_READ: begin
        cmd.issue = 1'b1;
      end
      ST_LAST: begin
      end
      ST_EMIT: begin
        cmd.load_out = sts.out_free;
        cmd.next_col = sts.out_free && !sts.job_end;
      end
      default: begin
      end
    endcase
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output register loaded while still occupied");

  a_last_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_LAST |-> $past(st_r) == ST_READ)
    else $error("final read cycle not preceded by a read");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !cmd.load_out)
    else $error("result loaded in the cycle after an accept");

endmodule

`default_nettype wire

[src/hrs_dp.sv]
// Datapath of the smoothing kernel: row bookkeeping, the bin window memory,
// the per-offset weighted accumulator and the output register.
// Depends on hrs_pkg and hrs_ram.
`default_nettype none

module hrs_dp #(
  parameter int MAX_KERNEL_WIDTH = hrs_pkg::DEF_MAX_KERNEL_WIDTH,
  parameter int MAX_COLUMNS      = hrs_pkg::DEF_MAX_COLUMNS,
  parameter int ENERGY_BITS      = hrs_pkg::DEF_ENERGY_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire hrs_pkg::cmd_t                     cmd,
  output hrs_pkg::sts_t                          sts,
  input  wire logic [ENERGY_BITS-1:0]            in_bin_energy,
  input  wire logic [hrs_pkg::KW_BITS-1:0]       in_kernel_width,
  input  wire logic                              in_last_in_row,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [hrs_pkg::SMEAR_BITS-1:0]         out_smeared_energy,
  output logic [hrs_pkg::COL_OUT_BITS-1:0]       out_column,
  output logic                                   out_row_done
);
  import hrs_pkg::*;

  localparam int WIN_DEPTH = 2 * MAX_KERNEL_WIDTH + 1;
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int CW        = $clog2(MAX_COLUMNS);
  localparam int CKW       = ((CW > KW_BITS) ? CW : KW_BITS) + 1;
  localparam int DW        = ((AW > KW_BITS) ? AW : KW_BITS) + 1;

  // Window address arithmetic modulo the window depth; offsets stay below it.
  function automatic logic [AW-1:0] addr_sub(input logic [AW-1:0] a, input step_t d);
    logic [DW-1:0] aw;
    logic [DW-1:0] dw;
    aw = DW'(a);
    dw = DW'(d);
    if (aw >= dw) begin
      addr_sub = AW'(aw - dw);
    end else begin
      addr_sub = AW'(aw + DW'(WIN_DEPTH) - dw);
    end
  endfunction

  function automatic logic [AW-1:0] addr_add(input logic [AW-1:0] a, input step_t d);
    logic [DW-1:0] s;
    s = DW'(a) + DW'(d);
    if (s >= DW'(WIN_DEPTH)) begin
      addr_add = AW'(s - DW'(WIN_DEPTH));
    end else begin
      addr_add = AW'(s);
    end
  endfunction

  // Row state.
  logic          row_active_r;
  logic [CW-1:0] col_cnt_r;
  logic [AW-1:0] wptr_r;
  step_t         kw_r;

  // Current result column.
  logic [CW-1:0] c_r, end_r, bound_r;
  logic [AW-1:0] caddr_r;
  logic          flush_r;

  // Read tag, registered so that it lines up with the read data.
  logic  iss_q_r, lz_q_r, rz_q_r, eop_q_r;
  step_t step_q_r;

  logic [ENERGY_BITS-1:0] lp_r, rp_r, lp_nxt, rp_nxt;
  logic [SMEAR_BITS-1:0]  acc_r, acc_nxt;

  logic                    out_valid_r;
  logic [SMEAR_BITS-1:0]   out_smear_r;
  logic [COL_OUT_BITS-1:0] out_col_r;
  logic                    out_done_r;

  // Accept-side decode.
  step_t          kw_in, kw_eff, back;
  logic [CW-1:0]  col, first_c;
  logic [AW-1:0]  wa;
  logic [CKW-1:0] col_w, kw_w;
  logic           last, col_ge_kw;

  always_comb begin
    kw_in = (32'(in_kernel_width) > 32'(MAX_KERNEL_WIDTH)) ?
            step_t'(MAX_KERNEL_WIDTH) : in_kernel_width;
    kw_eff    = row_active_r ? kw_r : kw_in;
    col       = row_active_r ? col_cnt_r : '0;
    wa        = row_active_r ? wptr_r : '0;
    last      = in_last_in_row || (col == CW'(MAX_COLUMNS - 1));
    col_w     = CKW'(col);
    kw_w      = CKW'(kw_eff);
    col_ge_kw = col_w >= kw_w;
    first_c   = col_ge_kw ? CW'(col_w - kw_w) : '0;
    back      = col_ge_kw ? kw_eff : step_t'(col);
  end

  // Read side: bins at c - d and c + d, zero outside the row.
  logic [AW-1:0]          raddr_a, raddr_b;
  logic [ENERGY_BITS-1:0] rd_a, rd_b;
  logic                   lz, rz, eop;

  always_comb begin
    raddr_a = addr_sub(caddr_r, cmd.step);
    raddr_b = addr_add(caddr_r, cmd.step);
    lz      = CKW'(cmd.step) > CKW'(c_r);
    rz      = (CKW'(c_r) + CKW'(cmd.step)) > CKW'(bound_r);
    eop     = !cmd.step[0] || (cmd.step == kw_r);
  end

  hrs_ram #(
    .WIDTH (ENERGY_BITS),
    .DEPTH (WIN_DEPTH)
  ) u_win (
    .clk     (clk),
    .we      (cmd.accept),
    .waddr   (wa),
    .wdata   (in_bin_energy),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  // Accumulate: odd offsets weigh one half, even offsets one quarter; each
  // pass pair sum is then shifted down by twice the pass number.
  logic [ENERGY_BITS-1:0] dl, dr, wl, wr, lsum, rsum;
  step_t                  sm1;
  logic [KW_BITS-1:0]     sh;

  always_comb begin
    dl      = lz_q_r ? '0 : rd_a;
    dr      = rz_q_r ? '0 : rd_b;
    wl      = step_q_r[0] ? (dl >> 1) : (dl >> 2);
    wr      = step_q_r[0] ? (dr >> 1) : (dr >> 2);
    lsum    = lp_r + wl;
    rsum    = rp_r + wr;
    sm1     = step_q_r - step_t'(1);
    sh      = {sm1[KW_BITS-1:1], 1'b0};
    lp_nxt  = lp_r;
    rp_nxt  = rp_r;
    acc_nxt = acc_r;
    if (iss_q_r) begin
      if (step_q_r == '0) begin
        acc_nxt = SMEAR_BITS'(dl);
        lp_nxt  = '0;
        rp_nxt  = '0;
      end else if (eop_q_r) begin
        acc_nxt = acc_r + SMEAR_BITS'(lsum >> sh) + SMEAR_BITS'(rsum >> sh);
        lp_nxt  = '0;
        rp_nxt  = '0;
      end else begin
        lp_nxt = lsum;
        rp_nxt = rsum;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_active_r <= 1'b0;
      col_cnt_r    <= '0;
      wptr_r       <= '0;
      kw_r         <= '0;
      flush_r      <= 1'b0;
      iss_q_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      iss_q_r <= cmd.issue;
      if (cmd.accept) begin
        row_active_r <= !last;
        col_cnt_r    <= last ? '0 : col + CW'(1);
        wptr_r       <= last ? '0 : addr_add(wa, step_t'(1));
        kw_r         <= kw_eff;
        flush_r      <= last;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    step_q_r <= cmd.step;
    lz_q_r   <= lz;
    rz_q_r   <= rz;
    eop_q_r  <= eop;
    lp_r     <= lp_nxt;
    rp_r     <= rp_nxt;
    acc_r    <= acc_nxt;
    if (cmd.accept) begin
      c_r     <= first_c;
      caddr_r <= addr_sub(wa, back);
      end_r   <= last ? col : first_c;
      bound_r <= col;
    end else if (cmd.next_col) begin
      c_r     <= c_r + CW'(1);
      caddr_r <= addr_add(caddr_r, step_t'(1));
    end
    if (cmd.load_out) begin
      out_smear_r <= acc_r;
      out_col_r   <= COL_OUT_BITS'(c_r);
      out_done_r  <= flush_r && (c_r == end_r);
    end
  end

  always_comb begin
    sts.emit      = last || col_ge_kw;
    sts.step_last = cmd.step == kw_r;
    sts.job_end   = c_r == end_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_smeared_energy = out_smear_r;
  assign out_column         = out_col_r;
  assign out_row_done       = out_done_r;

  a_col_in_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> c_r <= bound_r)
    else $error("result column beyond the newest written column");

  a_single_job: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue && !flush_r |-> c_r == end_r)
    else $error("mid-row transfer released more than one column");

  a_done_only_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out && !flush_r |=> !out_row_done)
    else $error("row end flagged outside a row flush");

endmodule

`default_nettype wire

[src/histogram_row_smear_pow2_kernel.sv]
// Top level of the histogram row smoothing kernel.
// Joins hrs_ctrl and hrs_dp; depends on hrs_pkg.
//
// Bins of one row arrive one per transfer on the in_ channel; kernel_width is
// taken from the row's first item and saturated to MAX_KERNEL_WIDTH. Once a
// column has all its neighbors it is smoothed and sent on the out_ channel;
// the item that ends a row (last_in_row, or column MAX_COLUMNS-1) releases
// every column still pending, the last one with row_done set. For each
// result the two-port window memory supplies the left and right neighbor
// at one offset per cycle (kernel_width + 1 reads including the bin
// itself); the last read data is then taken in, and the output register
// is loaded once it is free. Input is taken whenever the block is between
// items, even while a result waits in the output register. The window
// needs no clearing after reset.
`default_nettype none

module histogram_row_smear_pow2_kernel #(
  parameter int MAX_KERNEL_WIDTH = hrs_pkg::DEF_MAX_KERNEL_WIDTH,
  parameter int MAX_COLUMNS      = hrs_pkg::DEF_MAX_COLUMNS,
  parameter int ENERGY_BITS      = hrs_pkg::DEF_ENERGY_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ENERGY_BITS-1:0]            in_bin_energy,
  input  wire logic [hrs_pkg::KW_BITS-1:0]       in_kernel_width,
  input  wire logic                              in_last_in_row,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [hrs_pkg::SMEAR_BITS-1:0]         out_smeared_energy,
  output logic [hrs_pkg::COL_OUT_BITS-1:0]       out_column,
  output logic                                   out_row_done
);
  import hrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  hrs_dp #(
    .MAX_KERNEL_WIDTH (MAX_KERNEL_WIDTH),
    .MAX_COLUMNS      (MAX_COLUMNS),
    .ENERGY_BITS      (ENERGY_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_bin_energy      (in_bin_energy),
    .in_kernel_width    (in_kernel_width),
    .in_last_in_row     (in_last_in_row),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_smeared_energy (out_smeared_energy),
    .out_column         (out_column),
    .out_row_done       (out_row_done)
  );

endmodule

`default_nettype wire

[tb/sv/hrs_smear_checker.sv]
// Checker for the histogram row smoothing kernel: watches both channels,
// predicts the smoothed bins of every row and compares each result transfer.
// Depends on hrs_pkg for the result field widths and the default sizes.

module hrs_smear_checker #(
  parameter int MAX_KERNEL_WIDTH = hrs_pkg::DEF_MAX_KERNEL_WIDTH,
  parameter int MAX_COLUMNS      = hrs_pkg::DEF_MAX_COLUMNS,
  parameter int ENERGY_BITS      = hrs_pkg::DEF_ENERGY_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [ENERGY_BITS-1:0]             in_bin_energy,
  input  logic [hrs_pkg::KW_BITS-1:0]        in_kernel_width,
  input  logic                               in_last_in_row,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [hrs_pkg::SMEAR_BITS-1:0]     out_smeared_energy,
  input  logic [hrs_pkg::COL_OUT_BITS-1:0]   out_column,
  input  logic                               out_row_done,
  output int                                 fail_count,
  output int                                 pending
);

  localparam int WIN_DEPTH = 2 * MAX_KERNEL_WIDTH + 1;
  localparam int NO_RIGHT_EDGE = 32'h7fff_ffbf;

  typedef struct packed {
    logic [hrs_pkg::SMEAR_BITS-1:0]   energy;
    logic [hrs_pkg::COL_OUT_BITS-1:0] column;
    logic                             row_done;
  } smeared_bin_t;

  smeared_bin_t expected_bins[$];

  // Unsmoothed bins of the current row, kept by column modulo the depth.
  logic [ENERGY_BITS-1:0] bin_mem [WIN_DEPTH];
  int   next_col;
  int   row_kw;
  logic row_open;
  int   errors;

  function automatic longint unsigned bin_read(int col, int last_col);
    if (col < 0 || col > last_col) return 0;
    return longint'(bin_mem[col % WIN_DEPTH]);
  endfunction

  // Pass p looks at offsets 2p+1 and 2p+2; both pair sums shrink by 4^p.
  function automatic logic [hrs_pkg::SMEAR_BITS-1:0] smooth_column(int c, int last_col,
                                                                   int kw);
    longint unsigned acc, left_sum, right_sum;
    int w, off, sh;
    acc = bin_read(c, last_col);
    w   = kw;
    off = 1;
    sh  = 0;
    while (w > 0) begin
      left_sum  = bin_read(c - off, last_col) / 2;
      right_sum = bin_read(c + off, last_col) / 2;
      if (w >= 2) begin
        left_sum  += bin_read(c - off - 1, last_col) / 4;
        right_sum += bin_read(c + off + 1, last_col) / 4;
      end
      acc += (left_sum >> sh) + (right_sum >> sh);
      sh  += 2;
      w   -= 2;
      off += 2;
    end
    return acc[hrs_pkg::SMEAR_BITS-1:0];
  endfunction

  task automatic queue_bin(int c, int last_col, int kw, logic done);
    smeared_bin_t r;
    r.energy   = smooth_column(c, last_col, kw);
    r.column   = c[hrs_pkg::COL_OUT_BITS-1:0];
    r.row_done = done;
    expected_bins = {expected_bins, r};
  endtask

  task automatic predict_bins(logic [ENERGY_BITS-1:0] energy,
                              logic [hrs_pkg::KW_BITS-1:0] kw_in, logic last_flag);
    int   col;
    int   first_col;
    logic ends_row;
    if (!row_open) begin
      row_kw   = (int'(kw_in) > MAX_KERNEL_WIDTH) ? MAX_KERNEL_WIDTH : int'(kw_in);
      next_col = 0;
    end
    col = (next_col > MAX_COLUMNS - 1) ? MAX_COLUMNS - 1 : next_col;
    bin_mem[col % WIN_DEPTH] = energy;
    ends_row = last_flag || (col == MAX_COLUMNS - 1);
    if (!ends_row) begin
      // The column kernel-width places back now has every neighbor.
      if (col >= row_kw) queue_bin(col - row_kw, NO_RIGHT_EDGE, row_kw, 1'b0);
      next_col = col + 1;
      row_open = 1'b1;
    end else begin
      first_col = (col >= row_kw) ? col - row_kw : 0;
      for (int c = first_col; c <= col; c++) queue_bin(c, col, row_kw, c == col);
      next_col = 0;
      row_open = 1'b0;
    end
  endtask

  task automatic check_bin();
    smeared_bin_t exp_bin;
    if (expected_bins.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got energy %0d column %0d done %0b",
               $time, out_smeared_energy, out_column, out_row_done);
      return;
    end
    exp_bin = expected_bins.pop_front();
    if (out_smeared_energy !== exp_bin.energy) begin
      errors++;
      $display("%0t: column %0d smeared_energy expected %0d, got %0d", $time,
               exp_bin.column, exp_bin.energy, out_smeared_energy);
    end
    if (out_column !== exp_bin.column) begin
      errors++;
      $display("%0t: column expected %0d, got %0d", $time, exp_bin.column, out_column);
    end
    if (out_row_done !== exp_bin.row_done) begin
      errors++;
      $display("%0t: column %0d row_done expected %0b, got %0b", $time,
               exp_bin.column, exp_bin.row_done, out_row_done);
    end
  endtask

  initial begin
    errors     = 0;
    fail_count = 0;
    pending    = 0;
    next_col   = 0;
    row_kw     = 0;
    row_open   = 1'b0;
    for (int i = 0; i < WIN_DEPTH; i++) bin_mem[i] = '0;
  end

  // A result can never come from the input taken at the same edge, so the
  // output side is checked first.
  always @(posedge clk) begin
    if (!rst_n) begin
      expected_bins.delete();
      next_col = 0;
      row_kw   = 0;
      row_open = 1'b0;
    end else begin
      if (out_valid && out_ready) check_bin();
      if (in_valid && in_ready) predict_bins(in_bin_energy, in_kernel_width, in_last_in_row);
    end
    fail_count <= errors;
    pending    <= expected_bins.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the histogram row smoothing kernel: clock, reset, row
// stimulus, result back-pressure and the verdict.
// Depends on hrs_pkg, histogram_row_smear_pow2_kernel and hrs_smear_checker.

module tb_top;

  localparam int ENERGY_BITS = hrs_pkg::DEF_ENERGY_BITS;
  localparam int RANDOM_ITEMS = 360;
  localparam logic [ENERGY_BITS-1:0] ENERGY_MAX = '1;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic [ENERGY_BITS-1:0]           in_bin_energy;
  logic [hrs_pkg::KW_BITS-1:0]      in_kernel_width;
  logic                             in_last_in_row;
  logic                             out_valid;
  logic                             out_ready;
  logic [hrs_pkg::SMEAR_BITS-1:0]   out_smeared_energy;
  logic [hrs_pkg::COL_OUT_BITS-1:0] out_column;
  logic                             out_row_done;
  int                               fail_count;
  int                               pending;
  logic                             quiet;
  int                               random_sent;

  histogram_row_smear_pow2_kernel uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_bin_energy      (in_bin_energy),
    .in_kernel_width    (in_kernel_width),
    .in_last_in_row     (in_last_in_row),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_smeared_energy (out_smeared_energy),
    .out_column         (out_column),
    .out_row_done       (out_row_done)
  );

  hrs_smear_checker smear_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_bin_energy      (in_bin_energy),
    .in_kernel_width    (in_kernel_width),
    .in_last_in_row     (in_last_in_row),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_smeared_energy (out_smeared_energy),
    .out_column         (out_column),
    .out_row_done       (out_row_done),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  always #5 clk = ~clk;

  initial begin
    #50_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ENERGY_BITS-1:0] pick_energy();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 25) return ENERGY_MAX;
    if (r < 35) return ENERGY_BITS'($urandom_range(0, 255));
    return ENERGY_BITS'($urandom);
  endfunction

  function automatic logic [hrs_pkg::KW_BITS-1:0] pick_kw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return hrs_pkg::KW_BITS'(hrs_pkg::DEF_MAX_KERNEL_WIDTH);
    if (r < 30) return '0;
    return hrs_pkg::KW_BITS'($urandom);
  endfunction

  // Valid is only lowered when a gap follows, so it never drops and rises
  // again within one step.
  task automatic send_bin(logic [ENERGY_BITS-1:0] energy,
                          logic [hrs_pkg::KW_BITS-1:0] kw, logic last_flag);
    int gap;
    gap = quiet ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_bin_energy   <= energy;
    in_kernel_width <= kw;
    in_last_in_row  <= last_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Only the first item's width counts; the rest carry noise there.
  task automatic send_random_row(int len, logic [hrs_pkg::KW_BITS-1:0] kw, logic mark_end);
    for (int i = 0; i < len; i++) begin
      send_bin(pick_energy(), (i == 0) ? kw : hrs_pkg::KW_BITS'($urandom),
               mark_end && (i == len - 1));
      random_sent++;
    end
  endtask

  // Result side: ready runs of random length broken by stalls.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int stall;
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = quiet ? 0 : idle_cycles();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int len;
    int r;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_bin_energy   = '0;
    in_kernel_width = '0;
    in_last_in_row  = 1'b0;
    quiet           = 1'b0;
    random_sent     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A row of one bin at full width.
    send_bin(ENERGY_MAX, 4'd15, 1'b1);
    // No smoothing at all.
    send_bin(ENERGY_MAX, 4'd0, 1'b0);
    send_bin('0, 4'd15, 1'b0);
    send_bin(ENERGY_MAX, 4'd15, 1'b1);
    // Row shorter than the kernel: everything leaves on the last bin.
    send_bin(ENERGY_MAX, 4'd15, 1'b0);
    send_bin(ENERGY_MAX, 4'd0, 1'b0);
    send_bin(ENERGY_MAX, 4'd7, 1'b0);
    send_bin(ENERGY_MAX, 4'd0, 1'b1);
    // Width changes inside the row are ignored.
    send_bin(ENERGY_MAX, 4'd1, 1'b0);
    send_bin(24'h555555, 4'd15, 1'b0);
    send_bin(ENERGY_MAX, 4'd0, 1'b0);
    send_bin(24'haaaaaa, 4'd8, 1'b0);
    send_bin(ENERGY_MAX, 4'd2, 1'b1);
    // Odd width, so the last pass reads only the nearer neighbors.
    send_bin(24'h000001, 4'd3, 1'b0);
    send_bin(24'h800000, 4'd12, 1'b0);
    send_bin(24'h000003, 4'd5, 1'b0);
    send_bin(ENERGY_MAX, 4'd9, 1'b0);
    send_bin(24'h7fffff, 4'd10, 1'b0);
    send_bin(24'h000002, 4'd6, 1'b1);

    while (random_sent < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 10)      len = 1;
      else if (r < 70) len = $urandom_range(2, 16);
      else if (r < 95) len = $urandom_range(17, 40);
      else             len = $urandom_range(60, 100);
      if (random_sent == 0) send_random_row(3, pick_kw(), 1'b1);
      // One row runs to the column limit without a last mark.
      else if (random_sent < 40) send_random_row(hrs_pkg::DEF_MAX_COLUMNS, 4'd15, 1'b0);
      else send_random_row(len, pick_kw(), 1'b1);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    // The checker's pending count is registered, so it trails the queue.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
